FILE: rtl/core/wbss_pkg.sv
// ----------------------------------------------------------------------------
// wbss_pkg
// Shared types and constants for the wildcard byte signature search block.
// ----------------------------------------------------------------------------
package wbss_pkg;

  localparam int unsigned DATA_W          = 8;
  localparam int unsigned ADDR_W          = 48;
  localparam int unsigned LEN_W           = 5;
  localparam int unsigned SIG_REG_BYTES   = 16;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned MAX_SIG_BYTES_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO   = 2'd0,
    CFG_PAT_HI   = 2'd1,
    CFG_WILD     = 2'd2,
    CFG_LEN      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SIG_REG_BYTES*DATA_W-1:0] pattern;
    logic [SIG_REG_BYTES-1:0]        wild;
    logic [LEN_W-1:0]                length;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } res_t;

endpackage

FILE: rtl/core/wbss_cfg.sv
// ----------------------------------------------------------------------------
// wbss_cfg
// Configuration registers: signature bytes, wildcard mask and length.
// ----------------------------------------------------------------------------
module wbss_cfg import wbss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [CFG_DATA_W-1:0]    pat_lo_q, pat_hi_q;
  logic [SIG_REG_BYTES-1:0] wild_q;
  logic [LEN_W-1:0]         len_q;
  logic                     wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      wild_q   <= '0;
      len_q    <= LEN_W'(1);
    end else if (wr) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PAT_LO: pat_lo_q <= cfg_data_i;
        CFG_PAT_HI: pat_hi_q <= cfg_data_i;
        CFG_WILD:   wild_q   <= cfg_data_i[SIG_REG_BYTES-1:0];
        CFG_LEN:    len_q    <= cfg_data_i[LEN_W-1:0];
      endcase
    end
  end

  assign cfg_o.pattern = {pat_hi_q, pat_lo_q};
  assign cfg_o.wild    = wild_q;
  assign cfg_o.length  = len_q;

endmodule

FILE: rtl/core/wbss_match.sv
// ----------------------------------------------------------------------------
// wbss_match
// Input register, byte window and masked compare at every signature position.
// ----------------------------------------------------------------------------
module wbss_match import wbss_pkg::*; #(
  parameter int unsigned MaxSigBytes = MAX_SIG_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_byte_i,
  input  logic [ADDR_W-1:0] in_addr_i,
  input  logic              in_last_i,
  input  logic              out_ready_i,
  output logic              res_valid_o,
  output res_t              res_o
);

  localparam int unsigned LenCap    = (MaxSigBytes < SIG_REG_BYTES) ? MaxSigBytes
                                                                    : SIG_REG_BYTES;
  localparam int unsigned HistDepth = (LenCap > 1) ? LenCap - 1 : 1;
  localparam int unsigned SeenW     = $clog2(MaxSigBytes + 1);
  localparam int unsigned CmpW      = (SeenW > LEN_W) ? SeenW : LEN_W;

  logic              in_valid_q;
  logic [DATA_W-1:0] in_byte_q;
  logic [ADDR_W-1:0] in_addr_q;
  logic              in_last_q;

  logic [DATA_W-1:0] hist_q [HistDepth];
  logic [SeenW-1:0]  seen_q, seen_d;
  logic              found_q, found_d;

  logic              fire;
  logic [LEN_W-1:0]  len;
  logic [DATA_W-1:0] win [LenCap];
  logic [LenCap-1:0] pos_ok;
  logic              hit;
  logic [LEN_W-1:0]  k;
  logic [DATA_W-1:0] sel;

  assign fire       = in_valid_q & out_ready_i;
  assign in_ready_o = ~in_valid_q | out_ready_i;

  // Effective length: zero reads as one, clip to the window size
  always_comb begin
    len = cfg_i.length;
    if (len == '0) begin
      len = LEN_W'(1);
    end
    if (32'(len) > LenCap) begin
      len = LEN_W'(LenCap);
    end
  end

  always_comb begin
    win[0] = in_byte_q;
    for (int j = 1; j < LenCap; j++) begin
      win[j] = hist_q[j-1];
    end
  end

  always_comb begin
    for (int i = 0; i < LenCap; i++) begin
      k   = LEN_W'(len - LEN_W'(1) - LEN_W'(i));
      sel = '0;
      for (int j = 0; j < LenCap; j++) begin
        if (32'(k) == j) begin
          sel = win[j];
        end
      end
      pos_ok[i] = (32'(len) <= i) || cfg_i.wild[i] ||
                  (cfg_i.pattern[i*DATA_W +: DATA_W] == sel);
    end
  end

  always_comb begin
    seen_d      = seen_q;
    found_d     = found_q;
    hit         = 1'b0;
    res_valid_o = 1'b0;
    res_o.found = 1'b0;
    res_o.addr  = '0;
    if (fire) begin
      if (!found_q) begin
        if (32'(seen_q) < MaxSigBytes) begin
          seen_d = seen_q + SeenW'(1);
        end
        hit = (CmpW'(seen_d) >= CmpW'(len)) && (&pos_ok);
        if (hit) begin
          res_valid_o = 1'b1;
          res_o.found = 1'b1;
          res_o.addr  = in_addr_q - ADDR_W'(len - LEN_W'(1));
          found_d     = 1'b1;
        end else if (in_last_q) begin
          res_valid_o = 1'b1;
        end
      end
      if (in_last_q) begin
        seen_d  = '0;
        found_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      seen_q     <= '0;
      found_q    <= 1'b0;
      for (int j = 0; j < HistDepth; j++) begin
        hist_q[j] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      seen_q  <= seen_d;
      found_q <= found_d;
      if (fire && !found_q) begin
        hist_q[0] <= in_byte_q;
        for (int j = 1; j < HistDepth; j++) begin
          hist_q[j] <= hist_q[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_addr_q <= in_addr_i;
      in_last_q <= in_last_i;
    end
  end

  a_quiet_after_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && found_q |-> !res_valid_o)
    else $error("result produced after range already matched");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q |=> seen_q == '0 && !found_q)
    else $error("scan state not cleared at range end");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.found |-> res_o.addr == '0 && in_last_q)
    else $error("not-found result malformed");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(seen_q) <= MaxSigBytes)
    else $error("byte count beyond window size");

endmodule

FILE: rtl/core/wbss_oreg.sv
// ----------------------------------------------------------------------------
// wbss_oreg
// Result register between the compare logic and the output stream.
// ----------------------------------------------------------------------------
module wbss_oreg import wbss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  res_t              res_i,
  output logic              adv_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              out_o
);

  logic out_valid_q;
  res_t res_q;

  assign adv_o       = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: rtl/core/wildcard_byte_signature_search_top.sv
// ----------------------------------------------------------------------------
// wildcard_byte_signature_search_top
// Scans a byte stream for a masked signature and reports its start address.
//
//   Channel  Dir  Transfer on             Carries
//   s_axis   in   tvalid & tready         byte, address, range end (tlast)
//   m_axis   out  tvalid & tready         match address, found flag (tuser)
//   cfg      in   cfg_valid & cfg_ready   register index, write data
//
// One byte per cycle while the output is not stalled; the result is offered
// through the input register and the masked compare into the result register.
// Reset clears the byte window, the byte count and the found flag, and loads
// the configuration defaults. Output stall holds the result register and
// stops the input register; the cfg channel is always ready.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_search_top import wbss_pkg::*; #(
  parameter int unsigned MaxSigBytes = MAX_SIG_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [55:0]           s_axis_tdata,   // data_byte[7:0], byte_address[55:8]
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,   // match_address[47:0]
  output logic                  m_axis_tuser,   // match_found[0]
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg;
  logic res_valid;
  res_t res;
  logic adv;
  res_t out;

  wbss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wbss_match #(
    .MaxSigBytes (MaxSigBytes)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata[DATA_W-1:0]),
    .in_addr_i   (s_axis_tdata[DATA_W +: ADDR_W]),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (adv),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wbss_oreg u_oreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .adv_o       (adv),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tdata = out.addr;
  assign m_axis_tuser = out.found;

endmodule
